>>> rtl/pcsm_pkg.sv
// ----------------------------------------------------------------------------
// pcsm_pkg: shared types and constants of the p-code stack machine
// Holds the stack geometry, opcode, operation and fault codes, the sequencer
// state type and the multiply/divide control struct.
// ----------------------------------------------------------------------------
`default_nettype none
package pcsm_pkg;
    localparam int StackDepth = 4096;
    localparam int StackBits  = $clog2(StackDepth);
    localparam int CodeBits   = 11;
    localparam int WordBits   = 32;
    localparam int TopBits    = StackBits + 1;
    localparam int MaxLevel   = 3;

    typedef enum logic [2:0] {
        OP_LIT = 3'd0, OP_OPR = 3'd1, OP_LOD = 3'd2, OP_STO = 3'd3,
        OP_CAL = 3'd4, OP_INT = 3'd5, OP_JMP = 3'd6, OP_JPC = 3'd7
    } opcode_t;

    localparam logic [10:0] OPR_RET = 11'd0;
    localparam logic [10:0] OPR_NEG = 11'd1;
    localparam logic [10:0] OPR_ADD = 11'd2;
    localparam logic [10:0] OPR_SUB = 11'd3;
    localparam logic [10:0] OPR_MUL = 11'd4;
    localparam logic [10:0] OPR_DIV = 11'd5;
    localparam logic [10:0] OPR_ODD = 11'd6;
    localparam logic [10:0] OPR_EQ  = 11'd8;
    localparam logic [10:0] OPR_NE  = 11'd9;
    localparam logic [10:0] OPR_LT  = 11'd10;
    localparam logic [10:0] OPR_GE  = 11'd11;
    localparam logic [10:0] OPR_GT  = 11'd12;
    localparam logic [10:0] OPR_LE  = 11'd13;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_RANGE = 2'd1;
    localparam logic [1:0] FAULT_DIV0  = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RD_A, ST_RD_B, ST_LATCH_B, ST_WALK, ST_WALK_W,
        ST_EXEC, ST_RD_VAR, ST_VAR_W, ST_DIV, ST_WR2, ST_WR3, ST_FIN,
        ST_HALT, ST_RD_TOP, ST_TOP_W, ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic is_div;
        logic is_mul;
    } alu_ctl_t;
endpackage
`default_nettype wire

>>> rtl/pcode_stack_machine.sv
// ----------------------------------------------------------------------------
// pcode_stack_machine: PL/0 p-code instruction executor
// Runs one fetched instruction per input beat against an on-chip data stack.
// ----------------------------------------------------------------------------
// Usage: present one instruction (op, level, addr) as an s_ beat. The block
// executes it and returns one m_ beat with the next pc, base, top pointer,
// top word, halt flag and fault code. s_ready is low from acceptance until
// the result beat has been taken, so one instruction is in flight at a time.
// Simple instructions step through operand reads, execute, finish and a top
// read; each static link followed adds a walk step, lod adds a variable read,
// cal adds its frame writes, and mul and div run one bit a cycle in the shared
// multiply/divide unit. The single-port stack RAM serves one access at a time.
// After reset the block sweeps all 4096 stack words to zero, one a cycle,
// before raising s_ready for the first time. A halt (next pc zero) resets
// base and top and clears stack words 0 to 3.
// If the receiver stalls, the result beat holds on the m_ ports and no new
// instruction is taken until it is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module pcode_stack_machine
    import pcsm_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [2:0]              s_op,
    input  wire logic [1:0]              s_level,
    input  wire logic [10:0]             s_addr,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic      [10:0]             m_next_pc,
    output logic      [11:0]             m_base_index,
    output logic signed [12:0]           m_top_index,
    output logic signed [31:0]           m_top_value,
    output logic                         m_halted,
    output logic      [1:0]              m_fault
);
    state_t state_reg, state_next;

    logic [CodeBits-1:0]      pc_reg, pc_next;
    logic [StackBits-1:0]     b_reg, b_next;
    logic signed [TopBits-1:0] t_reg, t_next;
    logic [2:0]               op_reg;
    logic [1:0]               lev_reg, lev_next;
    logic [10:0]              a_reg;
    logic [WordBits-1:0]      x_reg, x_next, y_reg, y_next;
    logic [StackBits-1:0]     bl_reg, bl_next;
    logic [StackBits-1:0]     cnt_reg, cnt_next;
    logic [1:0]               fault_reg, fault_next;
    logic                     halt_reg, halt_next;
    logic [WordBits-1:0]      tv_reg, tv_next;

    logic                     ram_we;
    logic [StackBits-1:0]     ram_addr;
    logic [WordBits-1:0]      ram_wdata, ram_rdata;
    alu_ctl_t                 alu_ctl;
    logic                     alu_done;
    logic [WordBits-1:0]      alu_res;

    logic signed [TopBits+1:0] t_w;
    logic [StackBits+1:0]      bx;
    logic                      t_ge0, t_ge1, link_ok;
    logic [WordBits-1:0]       r_cmp;

    pcsm_ram #(.Width(WordBits), .Depth(StackDepth)) u_ram (
        .aclk (aclk), .we (ram_we), .addr (ram_addr),
        .wdata(ram_wdata), .rdata(ram_rdata)
    );

    pcsm_muldiv u_alu (
        .aclk(aclk), .aresetn(aresetn), .ctl(alu_ctl),
        .a(x_reg), .b(y_reg), .done(alu_done), .result(alu_res)
    );

    function automatic logic [StackBits-1:0] tix(input logic signed [TopBits-1:0] v);
        return v[StackBits-1:0];
    endfunction

    assign t_w     = (TopBits+2)'(t_reg);
    assign t_ge0   = !t_reg[TopBits-1];
    assign t_ge1   = t_ge0 && (t_reg != '0);
    assign link_ok = !ram_rdata[WordBits-1] && (ram_rdata < WordBits'(StackDepth));
    assign bx      = (StackBits+2)'(bl_reg) + (StackBits+2)'(a_reg);

    always_comb begin
        unique case (a_reg)
            OPR_EQ:  r_cmp = WordBits'(x_reg == y_reg);
            OPR_NE:  r_cmp = WordBits'(x_reg != y_reg);
            OPR_LT:  r_cmp = WordBits'($signed(x_reg) < $signed(y_reg));
            OPR_GE:  r_cmp = WordBits'($signed(x_reg) >= $signed(y_reg));
            OPR_GT:  r_cmp = WordBits'($signed(y_reg) < $signed(x_reg));
            OPR_LE:  r_cmp = WordBits'($signed(y_reg) >= $signed(x_reg));
            OPR_ADD: r_cmp = x_reg + y_reg;
            OPR_SUB: r_cmp = x_reg - y_reg;
            default: r_cmp = '0;
        endcase
    end

    // Next state and datapath updates.
    always_comb begin
        state_next = state_reg;
        pc_next = pc_reg; b_next = b_reg; t_next = t_reg;
        lev_next = lev_reg; x_next = x_reg; y_next = y_reg;
        bl_next = bl_reg; cnt_next = cnt_reg; fault_next = fault_reg;
        halt_next = halt_reg; tv_next = tv_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == {StackBits{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    fault_next = FAULT_NONE;
                    halt_next  = 1'b0;
                    lev_next   = (s_level > 2'(MaxLevel)) ? 2'(MaxLevel) : s_level;
                    bl_next    = b_reg;
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A: state_next = ST_RD_B;      // read t (or b+2 for ret)
            ST_RD_B: begin                      // read t-1 (or b+1)
                y_next = ram_rdata;
                state_next = ST_LATCH_B;
            end
            ST_LATCH_B: begin
                x_next = ram_rdata;
                if ((op_reg == OP_LOD || op_reg == OP_STO || op_reg == OP_CAL)
                        && lev_reg != 2'd0) begin
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_WALK: state_next = ST_WALK_W;
            ST_WALK_W: begin
                if (!link_ok) begin
                    // A broken link still advances the pc past the instruction.
                    fault_next = FAULT_RANGE;
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_FIN;
                end else begin
                    bl_next  = ram_rdata[StackBits-1:0];
                    lev_next = lev_reg - 1'b1;
                    state_next = (lev_reg == 2'd1) ? ST_EXEC : ST_WALK;
                end
            end
            ST_EXEC: begin
                pc_next    = pc_reg + 1'b1;
                state_next = ST_FIN;
                unique case (opcode_t'(op_reg))
                    OP_LIT: begin
                        if (t_w + 1 >= StackDepth) fault_next = FAULT_RANGE;
                        else t_next = t_reg + 1'b1;
                    end
                    OP_OPR: begin
                        if (a_reg == OPR_RET) begin
                            if ((StackBits+1)'(b_reg) + 2 >= StackDepth ||
                                    x_reg[WordBits-1] || x_reg >= WordBits'(StackDepth)) begin
                                fault_next = FAULT_RANGE;
                            end else begin
                                pc_next = y_reg[CodeBits-1:0];
                                t_next  = $signed({1'b0, b_reg}) - 13'sd1;
                                b_next  = x_reg[StackBits-1:0];
                            end
                        end else if (a_reg == OPR_NEG || a_reg == OPR_ODD) begin
                            if (!t_ge0) fault_next = FAULT_RANGE;
                        end else if ((a_reg >= OPR_ADD && a_reg <= OPR_DIV) ||
                                (a_reg >= OPR_EQ && a_reg <= OPR_LE)) begin
                            if (!t_ge1) begin
                                fault_next = FAULT_RANGE;
                            end else begin
                                t_next = t_reg - 1'b1;
                                if (a_reg == OPR_DIV && y_reg == '0) begin
                                    fault_next = FAULT_DIV0;
                                end else if (a_reg == OPR_MUL || a_reg == OPR_DIV) begin
                                    state_next = ST_DIV;
                                end
                            end
                        end
                    end
                    OP_LOD: begin
                        if (bx >= (StackBits+2)'(StackDepth) || t_w + 1 >= StackDepth)
                            fault_next = FAULT_RANGE;
                        else state_next = ST_RD_VAR;
                    end
                    OP_STO: begin
                        if (!t_ge0 || bx >= (StackBits+2)'(StackDepth))
                            fault_next = FAULT_RANGE;
                        else t_next = t_reg - 1'b1;
                    end
                    OP_CAL: begin
                        if (t_w + 3 >= StackDepth) begin
                            fault_next = FAULT_RANGE;
                        end else begin
                            state_next = ST_WR2;
                        end
                    end
                    OP_INT: begin
                        if (t_w + $signed((TopBits+2)'(a_reg)) >= StackDepth)
                            fault_next = FAULT_RANGE;
                        else t_next = TopBits'(t_w + $signed((TopBits+2)'(a_reg)));
                    end
                    OP_JMP: pc_next = a_reg;
                    OP_JPC: begin
                        if (!t_ge0) begin
                            fault_next = FAULT_RANGE;
                        end else begin
                            if (y_reg == '0) pc_next = a_reg;
                            t_next = t_reg - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_RD_VAR: state_next = ST_VAR_W;
            ST_VAR_W: begin
                t_next = t_reg + 1'b1;
                state_next = ST_FIN;
            end
            ST_DIV: if (alu_done) state_next = ST_FIN;
            ST_WR2: state_next = ST_WR3;
            ST_WR3: begin
                b_next  = tix(t_reg + 1'b1);
                pc_next = a_reg;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (pc_reg == '0) begin
                    halt_next = 1'b1;
                    b_next = '0;
                    t_next = '1;
                    cnt_next = '0;
                    state_next = ST_HALT;
                end else begin
                    state_next = ST_RD_TOP;
                end
            end
            ST_HALT: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == StackBits'(3)) state_next = ST_RD_TOP;
            end
            ST_RD_TOP: state_next = ST_TOP_W;
            ST_TOP_W: begin
                tv_next = t_ge0 ? ram_rdata : '0;
                state_next = ST_OUT;
            end
            ST_OUT: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // RAM port and unit control.
    always_comb begin
        ram_we = 1'b0;
        ram_addr = tix(t_reg);
        ram_wdata = '0;
        alu_ctl = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1; ram_addr = cnt_reg;
            end
            ST_HALT: begin
                ram_we = 1'b1; ram_addr = cnt_reg;
            end
            ST_RD_A: begin
                ram_addr = (op_reg == OP_OPR && a_reg == OPR_RET)
                         ? b_reg + 2'd2 : tix(t_reg);
            end
            ST_RD_B: begin
                ram_addr = (op_reg == OP_OPR && a_reg == OPR_RET)
                         ? b_reg + 1'b1 : tix(t_reg - 1'b1);
            end
            ST_WALK: ram_addr = bl_reg;
            ST_EXEC: begin
                unique case (opcode_t'(op_reg))
                    OP_LIT: begin
                        ram_we = (fault_next == FAULT_NONE);
                        ram_addr = tix(t_reg + 1'b1);
                        ram_wdata = WordBits'(a_reg);
                    end
                    OP_OPR: begin
                        if (fault_next == FAULT_DIV0) begin
                            ram_we = 1'b1; ram_addr = tix(t_reg - 1'b1);
                        end else if (state_next == ST_DIV) begin
                            alu_ctl.start  = 1'b1;
                            alu_ctl.is_div = (a_reg == OPR_DIV);
                            alu_ctl.is_mul = (a_reg == OPR_MUL);
                        end else if (fault_next == FAULT_NONE && a_reg == OPR_NEG) begin
                            ram_we = 1'b1; ram_wdata = ~y_reg + 1'b1;
                        end else if (fault_next == FAULT_NONE && a_reg == OPR_ODD) begin
                            ram_we = 1'b1; ram_wdata = WordBits'(y_reg[0]);
                        end else if (fault_next == FAULT_NONE && t_next != t_reg
                                && a_reg != OPR_RET) begin
                            ram_we = 1'b1; ram_addr = tix(t_reg - 1'b1);
                            ram_wdata = r_cmp;
                        end
                    end
                    OP_STO: begin
                        ram_we = (fault_next == FAULT_NONE);
                        ram_addr = bx[StackBits-1:0];
                        ram_wdata = y_reg;
                    end
                    OP_LOD: ram_addr = bx[StackBits-1:0];
                    OP_CAL: begin
                        ram_we = (fault_next == FAULT_NONE);
                        ram_addr = tix(t_reg + 1'b1);
                        ram_wdata = WordBits'(bl_reg);
                    end
                    default: ;
                endcase
            end
            ST_RD_VAR: ram_addr = bx[StackBits-1:0];
            ST_VAR_W: begin
                ram_we = 1'b1; ram_addr = tix(t_reg + 1'b1); ram_wdata = ram_rdata;
            end
            ST_DIV: begin
                ram_we = alu_done; ram_addr = tix(t_reg); ram_wdata = alu_res;
            end
            ST_WR2: begin
                ram_we = 1'b1; ram_addr = tix(t_reg + 3'sd2);
                ram_wdata = WordBits'(b_reg);
            end
            ST_WR3: begin
                ram_we = 1'b1; ram_addr = tix(t_reg + 3'sd3);
                ram_wdata = WordBits'(pc_reg);
            end
            ST_RD_TOP: ram_addr = tix(t_reg);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            pc_reg    <= '0;
            b_reg     <= '0;
            t_reg     <= '1;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            b_reg     <= b_next;
            t_reg     <= t_next;
            cnt_reg   <= cnt_next;
        end
        if (state_reg == ST_IDLE && s_valid) begin
            op_reg <= s_op;
            a_reg  <= s_addr;
        end
        lev_reg   <= lev_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        bl_reg    <= bl_next;
        fault_reg <= fault_next;
        halt_reg  <= halt_next;
        tv_reg    <= tv_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_OUT);
    assign m_next_pc    = pc_reg;
    assign m_base_index = b_reg;
    assign m_top_index  = t_reg;
    assign m_top_value  = tv_reg;
    assign m_halted     = halt_reg;
    assign m_fault      = fault_reg;

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output sides open together");
    a_top_range: assert property (@(posedge aclk) disable iff (!aresetn)
        t_reg >= -1) else $error("top pointer below empty");
    a_halt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_halted |-> m_next_pc == '0 && m_top_index == -1)
        else $error("halt without reinit");
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_top_index == -1 |-> m_top_value == '0)
        else $error("empty stack shows a word");
`endif
endmodule
`default_nettype wire

>>> rtl/pcsm_ram.sv
// ----------------------------------------------------------------------------
// pcsm_ram: generic single-port RAM
// One write or one read per cycle; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module pcsm_ram #(
    parameter int Width = 32,
    parameter int Depth = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> rtl/pcsm_muldiv.sv
// ----------------------------------------------------------------------------
// pcsm_muldiv: shared iterative multiply and divide unit
// Shift-add multiply and restoring signed divide, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pcsm_muldiv
    import pcsm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire alu_ctl_t            ctl,
    input  wire logic [WordBits-1:0] a,
    input  wire logic [WordBits-1:0] b,
    output logic                     done,
    output logic      [WordBits-1:0] result
);
    localparam int CntBits = $clog2(WordBits + 1);

    logic [WordBits-1:0] acc_reg, acc_next;
    logic [WordBits-1:0] q_reg, q_next;
    logic [WordBits-1:0] d_reg, d_next;
    logic [CntBits-1:0]  cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                div_reg, div_next;
    logic                neg_reg, neg_next;
    logic [WordBits:0]   trial;
    logic [WordBits-1:0] ma, md;

    always_comb begin
        ma = a[WordBits-1] ? (~a + 1'b1) : a;
        md = b[WordBits-1] ? (~b + 1'b1) : b;
        acc_next  = acc_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        trial     = {acc_reg, q_reg[WordBits-1]} - {1'b0, d_reg};
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = CntBits'(WordBits);
            div_next  = ctl.is_div;
            acc_next  = '0;
            if (ctl.is_div) begin
                q_next   = ma;
                d_next   = md;
                neg_next = a[WordBits-1] ^ b[WordBits-1];
            end else begin
                q_next   = a;
                d_next   = b;
                neg_next = 1'b0;
            end
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntBits'(1)) begin
                busy_next = 1'b0;
            end
            if (div_reg) begin
                if (!trial[WordBits]) begin
                    acc_next = trial[WordBits-1:0];
                    q_next   = {q_reg[WordBits-2:0], 1'b1};
                end else begin
                    acc_next = {acc_reg[WordBits-2:0], q_reg[WordBits-1]};
                    q_next   = {q_reg[WordBits-2:0], 1'b0};
                end
            end else begin
                // Product accumulates low bits only; wraps at word width.
                if (q_reg[0]) begin
                    acc_next = acc_reg + d_reg;
                end
                q_next = q_reg >> 1;
                d_next = d_reg << 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign done   = !busy_reg && !ctl.start;
    assign result = div_reg ? (neg_reg ? (~q_reg + 1'b1) : q_reg) : acc_reg;
endmodule
`default_nettype wire
